@@ design/quoted_command_line_assembler_defines.svh @@
// Assertion macros used by the top module of the command line assembler.
`ifndef QUOTED_COMMAND_LINE_ASSEMBLER_DEFINES_SVH
`define QUOTED_COMMAND_LINE_ASSEMBLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QCLA_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("command line assembler: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define QCLA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("command line assembler: next-cycle check failed");

`endif

@@ design/qcla_pkg.sv @@
// Types, constants and codes shared by the command line assembler modules.
package qcla_pkg;

	localparam int LINE_BYTES = 2048;
	localparam int ADDR_W     = $clog2(LINE_BYTES);
	localparam int BYTE_W     = 8;
	localparam int RIDX_W     = 11;
	localparam int CLEN_W     = 11;
	localparam int TIMEOUT_W  = 20;
	localparam int IDLE_W     = 21;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(30000);
	localparam logic [IDLE_W-1:0]    IDLE_MAX      = {IDLE_W{1'b1}};
	localparam logic [ADDR_W-1:0]    FILL_LIMIT    = ADDR_W'(LINE_BYTES - 2);

	localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
	localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		FN_BYTE = 2'd0,
		FN_TICK = 2'd1,
		FN_DONE = 2'd2,
		FN_READ = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_STORED     = 3'd0,
		ST_ERASED     = 3'd1,
		ST_CMD_READY  = 3'd2,
		ST_EMPTY_LINE = 3'd3,
		ST_OVERFLOW   = 3'd4,
		ST_BUSY_DROP  = 3'd5,
		ST_READ_DATA  = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_DECODE,
		FS_RDWAIT,
		FS_SCAN,
		FS_EMIT
	} fsm_t;

	typedef struct packed {
		func_t              func;
		logic [BYTE_W-1:0]  byte_value;
		logic [RIDX_W-1:0]  read_index;
	} item_t;

	typedef struct packed {
		logic is_zero;
		logic is_text;
		logic is_quote;
		logic is_erase;
		logic is_eol;
	} char_class_t;

	typedef struct packed {
		status_t            status;
		logic               timed_out;
		logic [CLEN_W-1:0]  cmd_length;
		logic [BYTE_W-1:0]  read_byte;
		logic               busy_res;
	} result_t;

endpackage

@@ design/quoted_command_line_assembler.sv @@
// Flow: a transaction is taken in idle, decoded and its result emitted; reads inside the command
// and backspaces that erase a byte also pass a read wait state, and a line end that walks the
// store passes the scan state, reading the single line store read port byte by byte. A new
// transaction is taken only after the last result has passed into the output register.
// Reset (arst_n low, asynchronous): line state, idle counter and busy flag clear, the timeout
// returns to 30000 ticks; the line store itself is not cleared and needs no clearing pass.
`include "quoted_command_line_assembler_defines.svh"

module quoted_command_line_assembler (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [7:0] byte_value, [18:8] read_index, [23:19] zero
	input  logic [1:0]  s_tuser,  // [1:0] func
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [0] timed_out, [11:1] cmd_length, [19:12] read_byte,
	                              // [20] busy_res, [23:21] zero
	output logic [2:0]  m_tuser,  // [2:0] status
	// Configuration write channel for idle_timeout_ticks.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [19:0] cfg_data
);
	import qcla_pkg::*;

	logic [TIMEOUT_W-1:0] timeout_q;
	item_t                item;
	logic                 core_ready;
	logic                 res_valid;
	logic                 res_ready;
	result_t              res;
	result_t              out_q;
	logic                 out_valid_q;

	// Always writable; the user must write the timeout only while idle; the block does not check.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid) begin
			timeout_q <= cfg_data;
		end
	end

	// Unpack the incoming transaction into the item record seen by the sequencer.
	always_comb begin
		item.func       = func_t'(s_tuser);
		item.byte_value = s_tdata[7:0];
		item.read_index = s_tdata[18:8];
	end

	assign s_tready = core_ready;

	qcla_core u_core (
		.clk                (clk),
		.arst_n             (arst_n),
		.item_valid         (s_tvalid),
		.item_ready         (core_ready),
		.item               (item),
		.idle_timeout_ticks (timeout_q),
		.res_valid          (res_valid),
		.res_ready          (res_ready),
		.res                (res)
	);

	// The output register parts the two sides: a finished result can wait here while the
	// sequencer already takes the next input transaction.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {3'b000, out_q.busy_res, out_q.read_byte, out_q.cmd_length,
		out_q.timed_out};

	// A busy drop can only be reported while a command is executing.
	`QCLA_ASSERT_SAME(a_busy_drop_busy, m_tvalid && m_tuser == ST_BUSY_DROP, m_tdata[20])
	// A ready command always leaves the block busy and has a non-empty length.
	`QCLA_ASSERT_SAME(a_cmd_ready_len, m_tvalid && m_tuser == ST_CMD_READY,
		m_tdata[20] && m_tdata[11:1] != 11'd0)
	// Read data is carried only by read results.
	`QCLA_ASSERT_SAME(a_read_byte_zero, m_tvalid && m_tuser != ST_READ_DATA,
		m_tdata[19:12] == 8'd0)
	// The sequencer takes one item at a time and is busy right after an acceptance.
	`QCLA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

endmodule

@@ design/qcla_line_ram.sv @@
// Single-port-write, single-port-read line store with registered read data.
module qcla_line_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ design/qcla_classify.sv @@
// Shared character compare unit: classifies one byte for the sequencer.
module qcla_classify (
	input  logic [qcla_pkg::BYTE_W-1:0] char_in,
	output qcla_pkg::char_class_t       char_class
);
	import qcla_pkg::*;

	always_comb begin
		char_class.is_zero  = (char_in == '0);
		// Unsigned compare, so bytes above 0x7F count as text as well.
		char_class.is_text  = (char_in > CH_SPACE);
		char_class.is_quote = (char_in == CH_QUOTE);
		char_class.is_erase = (char_in == CH_BS) || (char_in == CH_DEL);
		char_class.is_eol   = (char_in == CH_CR) || (char_in == CH_LF);
	end

endmodule

@@ design/qcla_core.sv @@
// Sequencer and line state of the command line assembler.
module qcla_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  qcla_pkg::item_t                item,
	input  logic [qcla_pkg::TIMEOUT_W-1:0] idle_timeout_ticks,
	output logic                           res_valid,
	input  logic                           res_ready,
	output qcla_pkg::result_t              res
);
	import qcla_pkg::*;

	fsm_t                state_q, state_d;
	item_t               item_q;
	logic [ADDR_W-1:0]   fill_q, fill_d;
	logic                quote_q, quote_d;
	logic [IDLE_W-1:0]   idle_q, idle_d;
	logic                exec_q, exec_d;
	logic [ADDR_W-1:0]   ready_len_q, ready_len_d;
	logic [ADDR_W-1:0]   scan_q, scan_d;
	status_t             status_q, status_d;
	logic                tout_q, tout_d;
	logic [CLEN_W-1:0]   clen_q, clen_d;
	logic [BYTE_W-1:0]   rbyte_q, rbyte_d;

	logic                timeout_hit;
	logic [ADDR_W-1:0]   fill_eff;
	logic                quote_eff;
	logic                read_in_range;
	logic                scan_last;
	logic [BYTE_W-1:0]   cls_byte;
	char_class_t         cls;

	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	logic [BYTE_W-1:0]   rd_data;

	qcla_line_ram #(
		.DEPTH (LINE_BYTES),
		.WIDTH (BYTE_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (item_q.byte_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// One compare unit serves the received byte and every byte read back.
	assign cls_byte = (state_q == FS_DECODE) ? item_q.byte_value : rd_data;

	qcla_classify u_classify (
		.char_in    (cls_byte),
		.char_class (cls)
	);

	assign timeout_hit   = idle_q > {1'b0, idle_timeout_ticks};
	assign fill_eff      = timeout_hit ? '0 : fill_q;
	assign quote_eff     = timeout_hit ? 1'b0 : quote_q;
	assign read_in_range = 32'(item_q.read_index) < 32'(ready_len_q);
	assign scan_last     = ({1'b0, scan_q} + 1'b1) == {1'b0, fill_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_IDLE: begin
				if (item_valid) begin
					state_d = FS_DECODE;
				end
			end
			FS_DECODE: begin
				state_d = FS_EMIT;
				case (item_q.func)
					FN_READ: begin
						if (read_in_range) begin
							state_d = FS_RDWAIT;
						end
					end
					FN_BYTE: begin
						if (!exec_q) begin
							if (cls.is_erase && fill_eff != '0) begin
								state_d = FS_RDWAIT;
							end else if (!cls.is_erase && cls.is_eol && !quote_eff &&
								fill_eff != '0) begin
								state_d = FS_SCAN;
							end
						end
					end
					default: state_d = FS_EMIT;
				endcase
			end
			FS_RDWAIT: state_d = FS_EMIT;
			FS_SCAN: begin
				if (cls.is_zero || cls.is_text || scan_last) begin
					state_d = FS_EMIT;
				end
			end
			FS_EMIT: begin
				if (res_ready) begin
					state_d = FS_IDLE;
				end
			end
			default: state_d = FS_IDLE;
		endcase
	end

	// Datapath and memory control.
	always_comb begin
		fill_d      = fill_q;
		quote_d     = quote_q;
		idle_d      = idle_q;
		exec_d      = exec_q;
		ready_len_d = ready_len_q;
		scan_d      = scan_q;
		status_d    = status_q;
		tout_d      = tout_q;
		clen_d      = clen_q;
		rbyte_d     = rbyte_q;
		wr_en       = 1'b0;
		wr_addr     = fill_eff;
		rd_en       = 1'b0;
		rd_addr     = '0;
		case (state_q)
			FS_DECODE: begin
				status_d = ST_STORED;
				tout_d   = 1'b0;
				clen_d   = '0;
				rbyte_d  = '0;
				case (item_q.func)
					FN_TICK: begin
						if (idle_q != IDLE_MAX) begin
							idle_d = idle_q + 1'b1;
						end
					end
					FN_DONE: exec_d = 1'b0;
					FN_READ: begin
						status_d = ST_READ_DATA;
						rd_en    = read_in_range;
						rd_addr  = ADDR_W'(item_q.read_index);
					end
					FN_BYTE: begin
						if (exec_q) begin
							status_d = ST_BUSY_DROP;
						end else begin
							tout_d  = timeout_hit && (fill_q != '0);
							fill_d  = fill_eff;
							quote_d = quote_eff;
							idle_d  = '0;
							if (cls.is_erase) begin
								if (fill_eff != '0) begin
									fill_d   = fill_eff - 1'b1;
									rd_en    = 1'b1;
									rd_addr  = fill_eff - 1'b1;
									status_d = ST_ERASED;
								end
							end else if (cls.is_eol && !quote_eff) begin
								fill_d   = '0;
								status_d = ST_EMPTY_LINE;
								scan_d   = '0;
								if (fill_eff != '0) begin
									rd_en  = 1'b1;
									fill_d = fill_eff;
								end
							end else if (fill_eff > FILL_LIMIT) begin
								status_d = ST_OVERFLOW;
							end else begin
								wr_en  = 1'b1;
								fill_d = fill_eff + 1'b1;
								if (cls.is_quote) begin
									quote_d = !quote_eff;
								end
							end
						end
					end
					default: status_d = ST_STORED;
				endcase
			end
			FS_RDWAIT: begin
				if (item_q.func == FN_READ) begin
					rbyte_d = rd_data;
				end else if (cls.is_quote) begin
					quote_d = !quote_q;
				end
			end
			FS_SCAN: begin
				if (cls.is_text && !cls.is_zero) begin
					exec_d      = 1'b1;
					ready_len_d = fill_q;
					clen_d      = CLEN_W'(fill_q);
					status_d    = ST_CMD_READY;
					fill_d      = '0;
				end else if (cls.is_zero || scan_last) begin
					status_d = ST_EMPTY_LINE;
					fill_d   = '0;
				end else begin
					scan_d  = scan_q + 1'b1;
					rd_en   = 1'b1;
					rd_addr = scan_q + 1'b1;
				end
			end
			default: begin
				fill_d = fill_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FS_IDLE;
			fill_q      <= '0;
			quote_q     <= 1'b0;
			idle_q      <= '0;
			exec_q      <= 1'b0;
			ready_len_q <= '0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			quote_q     <= quote_d;
			idle_q      <= idle_d;
			exec_q      <= exec_d;
			ready_len_q <= ready_len_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FS_IDLE && item_valid) begin
			item_q <= item;
		end
		scan_q   <= scan_d;
		status_q <= status_d;
		tout_q   <= tout_d;
		clen_q   <= clen_d;
		rbyte_q  <= rbyte_d;
	end

	// Outputs.
	always_comb begin
		item_ready     = (state_q == FS_IDLE);
		res_valid      = (state_q == FS_EMIT);
		res.status     = status_q;
		res.timed_out  = tout_q;
		res.cmd_length = clen_q;
		res.read_byte  = rbyte_q;
		res.busy_res   = exec_q;
	end

endmodule
